// ===== src/dfjd_pkg.sv =====
// ----------------------------------------------------------------------------
// dfjd_pkg: shared types and codes for the deadline FIFO job dispatcher
// Datapath command codes, record layout and controller/datapath interfaces.
// ----------------------------------------------------------------------------
package dfjd_pkg;

    localparam int unsigned MAX_REC     = 5;  // records reported per transaction
    localparam logic [2:0]  LIMIT_RESET = 3'd3;

    // datapath operations
    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_LOAD     = 3'd1; // latch input transaction
    localparam logic [2:0] CMD_FIRST    = 3'd2; // first job starts at once
    localparam logic [2:0] CMD_ARR      = 3'd3; // arrival decision
    localparam logic [2:0] CMD_COMPLETE = 3'd4; // finish running job
    localparam logic [2:0] CMD_SCAN     = 3'd5; // examine one FIFO head
    localparam logic [2:0] CMD_ENDFIN   = 3'd6; // final done and clear run
    localparam logic [2:0] CMD_FLUSH    = 3'd7; // send held record as last

    localparam logic KIND_DONE  = 1'b0;
    localparam logic KIND_ABORT = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] id;
        logic [31:0] evt;
        logic [31:0] delay;
    } rec_t;

    typedef struct packed {
        logic [2:0] op;
    } cmd_t;

    typedef struct packed {
        logic func;        // latched item is an end marker
        logic first_seen;
        logic arr_lt_fin;  // arrival before running job's finish
        logic busy;
        logic empty;       // no waiting job
        logic head_fits;   // FIFO head can still meet its deadline
        logic pend_valid;  // a record is held back
        logic stall;       // held record cannot move to the output yet
    } sts_t;

endpackage

// ===== src/dfjd_datapath.sv =====
// ----------------------------------------------------------------------------
// dfjd_datapath: job state, waiting FIFO and record staging
// Executes one controller command per cycle; a held record goes out once the
// next one exists or the transaction ends, so its last flag is known.
// ----------------------------------------------------------------------------
module dfjd_datapath #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  dfjd_pkg::cmd_t cmd,
    output dfjd_pkg::sts_t sts,
    input  logic          in_func,
    input  logic [15:0]   in_id,
    input  logic [31:0]   in_arr,
    input  logic [31:0]   in_len,
    input  logic [31:0]   in_dl,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_wdata,
    output logic          out_valid,
    input  logic          out_ready,
    output dfjd_pkg::rec_t out_rec,
    output logic          out_last
);
    import dfjd_pkg::*;

    localparam int IDXW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW   = CNTW + 1;

    logic [2:0]      lim_reg;
    logic            func_reg;
    logic [15:0]     id_reg;
    logic [31:0]     arr_reg, len_reg, dl_reg;
    logic [15:0]     wq_id  [QUEUE_DEPTH];
    logic [31:0]     wq_arr [QUEUE_DEPTH];
    logic [31:0]     wq_len [QUEUE_DEPTH];
    logic [31:0]     wq_dl  [QUEUE_DEPTH];
    logic [IDXW-1:0] head_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg, first_reg;
    logic [15:0]     cur_id_reg;
    logic [31:0]     cur_arr_reg, cur_len_reg, cpu_reg, fin_reg;
    logic            pend_valid_reg;
    rec_t            pend_reg;
    logic [2:0]      rec_cnt_reg;
    logic            out_valid_reg, out_last_reg;
    rec_t            out_reg;

    logic [CNTW-1:0] lim_eff;
    logic [SW-1:0]   tail_sum;
    logic [IDXW-1:0] tail_idx, head_nxt;
    logic [15:0]     h_id;
    logic [31:0]     h_arr, h_len, h_dl;
    logic [32:0]     head_sum, arr_fit_sum, start_sum, done_ref;
    logic [31:0]     start_t, start_fin, done_delay;
    logic            arr_fits, head_fits, arr_lt_fin;
    logic            emit_req, push_en, pend_load, out_load, stall;
    rec_t            emit_rec;

    always_comb
    begin
        if (32'(lim_reg) < 32'(QUEUE_DEPTH))
            lim_eff = CNTW'(lim_reg);
        else
            lim_eff = CNTW'(QUEUE_DEPTH);
        tail_sum = SW'(head_reg) + SW'(cnt_reg);
        if (tail_sum >= SW'(QUEUE_DEPTH))
            tail_sum = tail_sum - SW'(QUEUE_DEPTH);
        tail_idx = tail_sum[IDXW-1:0];
        head_nxt = (head_reg == IDXW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    end

    assign h_id  = wq_id[head_reg];
    assign h_arr = wq_arr[head_reg];
    assign h_len = wq_len[head_reg];
    assign h_dl  = wq_dl[head_reg];

    assign head_sum    = {1'b0, cpu_reg} + {1'b0, h_len};
    assign head_fits   = head_sum <= {1'b0, h_dl};
    assign arr_fit_sum = {1'b0, cpu_reg} + {1'b0, len_reg};
    assign arr_fits    = arr_fit_sum <= {1'b0, dl_reg};
    assign arr_lt_fin  = arr_reg < fin_reg;
    assign start_t     = (cpu_reg < arr_reg) ? arr_reg : cpu_reg;
    assign start_sum   = {1'b0, start_t} + {1'b0, len_reg};
    assign start_fin   = start_sum[32] ? 32'hFFFF_FFFF : start_sum[31:0];
    assign done_ref    = {1'b0, cur_arr_reg} + {1'b0, cur_len_reg};
    assign done_delay  = ({1'b0, fin_reg} > done_ref) ? fin_reg - done_ref[31:0] : '0;

    // record produced by the current command
    always_comb
    begin
        emit_req = 1'b0;
        push_en  = 1'b0;
        emit_rec = '{kind: KIND_DONE, id: cur_id_reg, evt: fin_reg, delay: done_delay};
        case (cmd.op)
            CMD_ARR:
            begin
                if (arr_lt_fin)
                begin
                    if (cnt_reg < lim_eff)
                        push_en = 1'b1;
                    else
                    begin
                        emit_req = 1'b1;
                        emit_rec = '{kind: KIND_ABORT, id: id_reg, evt: arr_reg, delay: '0};
                    end
                end
                else if (!busy_reg && !arr_fits)
                begin
                    emit_req = 1'b1;
                    emit_rec = '{kind: KIND_ABORT, id: id_reg, evt: dl_reg,
                                 delay: (dl_reg > arr_reg) ? dl_reg - arr_reg : '0};
                end
            end
            CMD_COMPLETE, CMD_ENDFIN:
                emit_req = busy_reg;
            CMD_SCAN:
            begin
                if (!head_fits)
                begin
                    emit_req = 1'b1;
                    if (h_dl > cpu_reg)
                        emit_rec = '{kind: KIND_ABORT, id: h_id, evt: h_dl,
                                     delay: (h_dl > h_arr) ? h_dl - h_arr : '0};
                    else
                        emit_rec = '{kind: KIND_ABORT, id: h_id, evt: cpu_reg,
                                     delay: (cpu_reg > h_arr) ? cpu_reg - h_arr : '0};
                end
            end
            default:
                emit_req = 1'b0;
        endcase
    end

    assign pend_load = emit_req && (rec_cnt_reg < 3'(MAX_REC));
    assign out_load  = (pend_load && pend_valid_reg) || (cmd.op == CMD_FLUSH);
    assign stall     = pend_valid_reg && out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg        <= LIMIT_RESET;
            head_reg       <= '0;
            cnt_reg        <= '0;
            busy_reg       <= 1'b0;
            first_reg      <= 1'b0;
            cur_id_reg     <= '0;
            cur_arr_reg    <= '0;
            cur_len_reg    <= '0;
            cpu_reg        <= '0;
            fin_reg        <= '0;
            pend_valid_reg <= 1'b0;
            rec_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                lim_reg <= cfg_wdata;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= (cmd.op == CMD_FLUSH);
            end
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (pend_load)
            begin
                pend_valid_reg <= 1'b1;
                rec_cnt_reg    <= rec_cnt_reg + 1'b1;
            end
            case (cmd.op)
                CMD_LOAD:
                    rec_cnt_reg <= '0;
                CMD_FIRST:
                begin
                    first_reg   <= 1'b1;
                    busy_reg    <= 1'b1;
                    cur_id_reg  <= id_reg;
                    cur_arr_reg <= arr_reg;
                    cur_len_reg <= len_reg;
                    cpu_reg     <= arr_reg;
                    fin_reg     <= start_fin; // start is arr: cpu time is still zero for the first job of a run
                end
                CMD_ARR:
                begin
                    if (arr_lt_fin)
                    begin
                        cpu_reg <= arr_reg;
                        if (push_en)
                            cnt_reg <= cnt_reg + 1'b1;
                    end
                    else if (!busy_reg)
                    begin
                        if (arr_fits)
                        begin
                            busy_reg    <= 1'b1;
                            cur_id_reg  <= id_reg;
                            cur_arr_reg <= arr_reg;
                            cur_len_reg <= len_reg;
                            cpu_reg     <= start_t;
                            fin_reg     <= start_fin;
                        end
                        else if (cpu_reg < dl_reg)
                            cpu_reg <= dl_reg;
                    end
                end
                CMD_COMPLETE:
                begin
                    cpu_reg  <= fin_reg;
                    busy_reg <= 1'b0;
                end
                CMD_SCAN:
                begin
                    head_reg <= head_nxt;
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (head_fits)
                    begin
                        busy_reg    <= 1'b1;
                        cur_id_reg  <= h_id;
                        cur_arr_reg <= h_arr;
                        cur_len_reg <= h_len;
                        fin_reg     <= head_sum[31:0];
                    end
                    else if (h_dl > cpu_reg)
                        cpu_reg <= h_dl;
                end
                CMD_ENDFIN:
                begin
                    head_reg    <= '0;
                    cnt_reg     <= '0;
                    busy_reg    <= 1'b0;
                    first_reg   <= 1'b0;
                    cur_id_reg  <= '0;
                    cur_arr_reg <= '0;
                    cur_len_reg <= '0;
                    cpu_reg     <= '0;
                    fin_reg     <= '0;
                end
                CMD_FLUSH:
                    pend_valid_reg <= 1'b0;
                default:
                    cpu_reg <= cpu_reg;
            endcase
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_LOAD)
        begin
            func_reg <= in_func;
            id_reg   <= in_id;
            arr_reg  <= in_arr;
            len_reg  <= in_len;
            dl_reg   <= in_dl;
        end
        if (push_en)
        begin
            wq_id[tail_idx]  <= id_reg;
            wq_arr[tail_idx] <= arr_reg;
            wq_len[tail_idx] <= len_reg;
            wq_dl[tail_idx]  <= dl_reg;
        end
        if (out_load)
            out_reg <= pend_reg;
        if (pend_load)
            pend_reg <= emit_rec;
    end

    assign sts = '{func: func_reg, first_seen: first_reg, arr_lt_fin: arr_lt_fin,
                   busy: busy_reg, empty: (cnt_reg == '0), head_fits: head_fits,
                   pend_valid: pend_valid_reg, stall: stall};

    assign out_valid = out_valid_reg;
    assign out_rec   = out_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== src/dfjd_ctrl.sv =====
// ----------------------------------------------------------------------------
// dfjd_ctrl: dispatcher sequencer
// Walks one transaction through first-job, arrival, completion, FIFO scan and end steps.
// ----------------------------------------------------------------------------
module dfjd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  dfjd_pkg::sts_t sts,
    output dfjd_pkg::cmd_t cmd
);
    import dfjd_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_ARR      = 3'd2;
    localparam logic [2:0] S_COMPLETE = 3'd3;
    localparam logic [2:0] S_SCAN     = 3'd4;
    localparam logic [2:0] S_ENDLOOP  = 3'd5;
    localparam logic [2:0] S_FINISH   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       ret_end_reg, ret_end_next;

    always_comb
    begin
        state_next   = state_reg;
        ret_end_next = ret_end_reg;
        cmd.op       = CMD_NONE;
        in_ready     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = CMD_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (sts.func)
                    state_next = S_ENDLOOP;
                else if (!sts.first_seen)
                begin
                    cmd.op     = CMD_FIRST;
                    state_next = S_FINISH;
                end
                else
                    state_next = S_ARR;
            end
            S_ARR:
            begin
                if (!sts.stall)
                begin
                    cmd.op = CMD_ARR;
                    if (sts.arr_lt_fin || !sts.busy)
                        state_next = S_FINISH;
                    else
                    begin
                        ret_end_next = 1'b0;
                        state_next   = S_COMPLETE;
                    end
                end
            end
            S_COMPLETE:
            begin
                if (!sts.stall)
                begin
                    cmd.op     = CMD_COMPLETE;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.empty)
                    state_next = ret_end_reg ? S_ENDLOOP : S_ARR;
                else if (!sts.stall)
                begin
                    cmd.op = CMD_SCAN;
                    if (sts.head_fits)
                        state_next = ret_end_reg ? S_ENDLOOP : S_ARR;
                end
            end
            S_ENDLOOP:
            begin
                if (!sts.empty)
                begin
                    ret_end_next = 1'b1;
                    state_next   = S_COMPLETE;
                end
                else if (!sts.stall)
                begin
                    cmd.op     = CMD_ENDFIN;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!sts.pend_valid)
                    state_next = S_IDLE;
                else if (!sts.stall)
                begin
                    cmd.op     = CMD_FLUSH;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ret_end_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_end_reg <= ret_end_next;
        end
    end

endmodule

// ===== src/deadline_fifo_job_dispatcher.sv =====
// ----------------------------------------------------------------------------
// deadline_fifo_job_dispatcher: single-processor FIFO dispatcher with deadlines
// Jobs run one at a time; waiting jobs sit in a bounded FIFO and are aborted
// when they can no longer meet their deadline. Emits done/abort records.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tuser=func, tdata=id,arr,len,deadline
//  m_*     | out | m_tvalid/m_tready  | tuser=kind, tdata=id,time,delay, tlast
//  cfg_*   | in  | cfg_we             | cfg_wdata=queue_limit
//
//  The first job of a run steps through accept, dispatch and finish; an arrival
//  decided at once through accept, dispatch, decide and finish; an end marker
//  with nothing waiting through accept, dispatch, end check and finish. A
//  completion adds its step and the retested decision or end check, a scan
//  step per entry, one more at an empty FIFO; one step per cycle unless stalled.
//  Reset clears job state and sets queue_limit to 3; the FIFO has no clear.
//  A record step waits while a record is held back and the output register is
//  full and not taken; s_tready is high only between transactions.
//
module deadline_fifo_job_dispatcher #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // job_id, arrival_time, run_length, deadline
    input  logic         s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata,   // record_id, event_time, wait_delay
    output logic         m_tuser,   // record_kind
    output logic         m_tlast,   // last_record
    input  logic         cfg_we,
    input  logic [2:0]   cfg_wdata  // queue_limit
);
    import dfjd_pkg::*;

    cmd_t cmd;
    sts_t sts;
    rec_t out_rec;

    dfjd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dfjd_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_func   (s_tuser),
        .in_id     (s_tdata[15:0]),
        .in_arr    (s_tdata[47:16]),
        .in_len    (s_tdata[79:48]),
        .in_dl     (s_tdata[111:80]),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rec   (out_rec),
        .out_last  (m_tlast)
    );

    // pack record, id in the low bits
    assign m_tdata = {out_rec.delay, out_rec.evt, out_rec.id};
    assign m_tuser = out_rec.kind;

`ifndef SYNTHESIS
    // between transactions no record is held back
    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !sts.pend_valid) else $error("record held while idle");

    // one transaction at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready) else $error("second transaction taken");

    // a stall only occurs with a full output register
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        sts.stall |-> m_tvalid) else $error("stall without output");

    // no datapath step while idle other than load
    a_idle_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (cmd.op == CMD_NONE || cmd.op == CMD_LOAD))
        else $error("datapath step while idle");
`endif

endmodule

// ===== bench/deadline_fifo_job_dispatcher_tb.sv =====
// ----------------------------------------------------------------------------
// deadline_fifo_job_dispatcher_tb: self-checking bench for the job dispatcher
// Drives job arrivals and end markers, predicts done/abort records with a
// behavioral scheduler model, and checks every record field by field.
// ----------------------------------------------------------------------------
module deadline_fifo_job_dispatcher_tb;
    import dfjd_pkg::*;

    localparam int DEPTH     = 4;
    localparam int MAX_CYC   = 400000;
    localparam int TAIL_CYC  = 60;

    localparam logic FUNC_ARRIVE = 1'b0;
    localparam logic FUNC_END    = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] id;
        logic [31:0] arr;
        logic [31:0] len;
        logic [31:0] dl;
    } job_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] id;
        logic [31:0] evt;
        logic [31:0] delay;
        logic        last;
    } record_t;

    // directed row: job plus optional typed-in first record
    typedef struct {
        job_t    job;
        bit      typed;
        record_t first_rec;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;   // job_id, arrival_time, run_length, deadline
    logic         s_tuser;   // func
    logic         m_tvalid;
    logic         m_tready;
    logic [79:0]  m_tdata;   // record_id, event_time, wait_delay
    logic         m_tuser;   // record_kind
    logic         m_tlast;   // last_record
    logic         cfg_we;
    logic [2:0]   cfg_wdata; // queue_limit

    deadline_fifo_job_dispatcher #(.QUEUE_DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ---------------------------------------------------------------- scheduler model
    logic [2:0]  lim_reg;
    logic [15:0] wq_id  [DEPTH];
    logic [31:0] wq_arr [DEPTH];
    logic [31:0] wq_len [DEPTH];
    logic [31:0] wq_dl  [DEPTH];
    int          wq_head, wq_cnt;
    bit          running, seen_job;
    logic [15:0] run_id;
    logic [31:0] run_arr, run_len, cpu_now, fin_at;

    record_t pending_recs[$];   // records still to come from the DUT
    record_t item_recs[$];      // records of the item being predicted
    int      item_total;
    int      errors;
    int      cycles;

    function automatic logic [31:0] clip_sub(logic [32:0] a, logic [32:0] b);
        return (a > b) ? 32'(a - b) : 32'd0;
    endfunction

    function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    task automatic log_rec(logic kind, logic [15:0] id, logic [31:0] evt, logic [31:0] dly);
        record_t r;
        r = '{kind: kind, id: id, evt: evt, delay: dly, last: 1'b0};
        if (item_total < MAX_REC) item_recs.insert(item_recs.size(), r);
        item_total++;
    endtask

    task automatic clear_sched();
        wq_head = 0; wq_cnt = 0; running = 0; seen_job = 0;
        run_id = '0; run_arr = '0; run_len = '0; cpu_now = '0; fin_at = '0;
    endtask

    task automatic finish_and_scan();
        logic [15:0] id;
        logic [31:0] a, l, d;
        cpu_now = fin_at;
        if (running)
        begin
            log_rec(KIND_DONE, run_id, cpu_now,
                    clip_sub({1'b0, cpu_now}, {1'b0, run_arr} + {1'b0, run_len}));
            running = 0;
        end
        while (wq_cnt > 0)
        begin
            id = wq_id[wq_head]; a = wq_arr[wq_head];
            l = wq_len[wq_head]; d = wq_dl[wq_head];
            wq_head = (wq_head + 1) % DEPTH;
            wq_cnt--;
            if ({1'b0, cpu_now} + {1'b0, l} <= {1'b0, d})
            begin
                running = 1; run_id = id; run_arr = a; run_len = l;
                fin_at = cpu_now + l;
                return;
            end
            if (d > cpu_now)
            begin
                cpu_now = d;
                log_rec(KIND_ABORT, id, d, clip_sub({1'b0, d}, {1'b0, a}));
            end
            else
                log_rec(KIND_ABORT, id, cpu_now, clip_sub({1'b0, cpu_now}, {1'b0, a}));
        end
    endtask

    // computes the records one input transaction causes and queues them
    task automatic predict_records(job_t j);
        int lim, t;
        lim = (lim_reg < DEPTH) ? lim_reg : DEPTH;
        item_recs.delete();
        item_total = 0;
        if (j.func == FUNC_END)
        begin
            while (wq_cnt > 0) finish_and_scan();
            if (running)
            begin
                cpu_now = fin_at;
                log_rec(KIND_DONE, run_id, cpu_now,
                        clip_sub({1'b0, cpu_now}, {1'b0, run_arr} + {1'b0, run_len}));
            end
            clear_sched();
        end
        else if (!seen_job)
        begin
            seen_job = 1; running = 1;
            run_id = j.id; run_arr = j.arr; run_len = j.len;
            fin_at = sat_add(j.arr, j.len);
            cpu_now = j.arr;
        end
        else
        begin
            forever
            begin
                if (j.arr < fin_at)
                begin
                    cpu_now = j.arr;
                    if (wq_cnt < lim)
                    begin
                        t = (wq_head + wq_cnt) % DEPTH;
                        wq_id[t] = j.id; wq_arr[t] = j.arr;
                        wq_len[t] = j.len; wq_dl[t] = j.dl;
                        wq_cnt++;
                    end
                    else
                        log_rec(KIND_ABORT, j.id, j.arr, 32'd0);
                    break;
                end
                if (!running)
                begin
                    if ({1'b0, cpu_now} + {1'b0, j.len} <= {1'b0, j.dl})
                    begin
                        running = 1; run_id = j.id; run_arr = j.arr; run_len = j.len;
                        if (cpu_now < j.arr) cpu_now = j.arr;
                        fin_at = sat_add(cpu_now, j.len);
                    end
                    else
                    begin
                        if (cpu_now < j.dl) cpu_now = j.dl;
                        log_rec(KIND_ABORT, j.id, j.dl, clip_sub({1'b0, j.dl}, {1'b0, j.arr}));
                    end
                    break;
                end
                finish_and_scan();
            end
        end
        if (item_recs.size() > 0) item_recs[item_recs.size() - 1].last = 1'b1;
        foreach (item_recs[k]) pending_recs.insert(pending_recs.size(), item_recs[k]);
    endtask

    // ---------------------------------------------------------------- stimulus
    bit   idle_ok = 1;     // random gaps allowed
    bit   hold_sink = 0;   // long receiver hold-off request
    int   sent;
    logic [31:0] now_t;    // running arrival clock for random jobs

    // tvalid stays up after a transaction; the next item or a drain wait takes it over
    task automatic send_job(job_t j);
        int gap;
        if (idle_ok && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= j.func;
        s_tdata  <= {j.dl, j.len, j.arr, j.id};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_records(j);
        sent++;
    endtask

    // waits for every predicted record, then the datapath tail
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_recs.size() > 0) @(posedge clk);
        repeat (TAIL_CYC) @(posedge clk);
    endtask

    task automatic write_limit(logic [2:0] v);
        wait_drained();
        cfg_we <= 1'b1; cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        lim_reg = v;
    endtask

    function automatic job_t mk(logic f, logic [15:0] id, logic [31:0] a,
                                logic [31:0] l, logic [31:0] d);
        return '{func: f, id: id, arr: a, len: l, dl: d};
    endfunction

    // random arrival; mostly plausible timings around a growing clock
    function automatic job_t rand_job(int mode);
        job_t j;
        j.func = FUNC_ARRIVE;
        j.id   = 16'($urandom);
        if (mode == 0)
        begin
            now_t = now_t + $urandom_range(0, 40);
            j.arr = now_t;
            j.len = $urandom_range(0, 60);
            j.dl  = now_t + $urandom_range(0, 150);
        end
        else
        begin
            // extreme values: exercise high bits and overflow saturation
            now_t = now_t + ($urandom_range(0, 1) ? 32'($urandom) >> $urandom_range(0, 31) : 0);
            j.arr = now_t;
            j.len = $urandom;
            j.dl  = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
        end
        return j;
    endfunction

    row_t dir_rows[$];

    task automatic add_row(job_t j, bit typed, record_t rec);
        row_t r;
        r.job       = j;
        r.typed     = typed;
        r.first_rec = rec;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic check_typed(int r, record_t want, record_t got);
        if (got.kind !== want.kind)
        begin
            $error("row %0d record_kind expected %0d actual %0d", r, want.kind, got.kind);
            errors++;
        end
        if (got.id !== want.id)
        begin
            $error("row %0d record_id expected %0d actual %0d", r, want.id, got.id);
            errors++;
        end
        if (got.evt !== want.evt)
        begin
            $error("row %0d event_time expected %0d actual %0d", r, want.evt, got.evt);
            errors++;
        end
        if (got.delay !== want.delay)
        begin
            $error("row %0d wait_delay expected %0d actual %0d", r, want.delay, got.delay);
            errors++;
        end
        if (got.last !== want.last)
        begin
            $error("row %0d last_record expected %0d actual %0d", r, want.last, got.last);
            errors++;
        end
    endtask

    task automatic run_directed();
        // end with nothing seen: no record
        add_row(mk(FUNC_END, 0, 0, 0, 0), 0, '0);
        // first job starts at once, even at top values (finish saturates)
        add_row(mk(FUNC_ARRIVE, 16'hFFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 0), 0, '0);
        add_row(mk(FUNC_ARRIVE, 16'h0001, 32'hFFFF_FFF1, 5, 32'hFFFF_FFFF), 0, '0);
        // end: running job done at the saturated finish, then the waiting job aborted
        add_row(mk(FUNC_END, 0, 0, 0, 0), 1,
            '{kind: KIND_DONE, id: 16'hFFFF, evt: 32'hFFFF_FFFF, delay: 32'd0, last: 0});
        // fill the FIFO, then an arrival aborted on a full FIFO with zero delay
        add_row(mk(FUNC_ARRIVE, 10, 0, 100, 100), 0, '0);
        add_row(mk(FUNC_ARRIVE, 11, 1, 10, 50), 0, '0);
        add_row(mk(FUNC_ARRIVE, 12, 2, 10, 300), 0, '0);
        add_row(mk(FUNC_ARRIVE, 13, 3, 10, 115), 0, '0);
        add_row(mk(FUNC_ARRIVE, 14, 4, 10, 200), 1,
            '{kind: KIND_ABORT, id: 14, evt: 4, delay: 0, last: 1});
        // late arrival: completion, scan aborts, start, then retest
        add_row(mk(FUNC_ARRIVE, 15, 500, 0, 0), 1,
            '{kind: KIND_DONE, id: 10, evt: 100, delay: 0, last: 0});
        // idle arrival that cannot fit: aborted at its deadline
        add_row(mk(FUNC_ARRIVE, 16, 600, 50, 20), 0, '0);
        add_row(mk(FUNC_ARRIVE, 17, 700, 1, 800), 0, '0);
        add_row(mk(FUNC_ARRIVE, 18, 700, 10, 0), 0, '0);
        add_row(mk(FUNC_END, 0, 0, 0, 0), 0, '0);
        // five or more records from one arrival: only five are reported
        add_row(mk(FUNC_ARRIVE, 20, 0, 1000, 1000), 0, '0);
        for (int k = 0; k < 4; k++)
            add_row(mk(FUNC_ARRIVE, 16'(21 + k), 32'(k + 1), 5, 32'(k)), 0, '0);
        add_row(mk(FUNC_ARRIVE, 25, 5000, 1, 1), 0, '0);
        add_row(mk(FUNC_END, 0, 0, 0, 0), 0, '0);

        foreach (dir_rows[r])
        begin
            if (r == 4) write_limit(3'd3);
            if (r == 14) write_limit(3'd4);
            send_job(dir_rows[r].job);
            if (dir_rows[r].typed)
            begin
                if (item_recs.size() == 0)
                begin
                    $error("row %0d record expected %h actual none", r, dir_rows[r].first_rec);
                    errors++;
                end
                else
                    check_typed(r, dir_rows[r].first_rec, item_recs[0]);
            end
        end
    endtask

    // ---------------------------------------------------------------- sink and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_sink)
            m_tready <= 1'b0;
        else if (idle_ok && $urandom_range(0, 5) == 0)
            m_tready <= 1'b0;
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        record_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_recs.size() == 0)
            begin
                $error("unexpected record id %h", m_tdata[15:0]);
                errors++;
            end
            else
            begin
                want = pending_recs.pop_front();
                if (m_tuser !== want.kind)
                begin
                    $error("record_kind expected %0d actual %0d", want.kind, m_tuser);
                    errors++;
                end
                if (m_tdata[15:0] !== want.id)
                begin
                    $error("record_id expected %0d actual %0d", want.id, m_tdata[15:0]);
                    errors++;
                end
                if (m_tdata[47:16] !== want.evt)
                begin
                    $error("event_time expected %0d actual %0d", want.evt, m_tdata[47:16]);
                    errors++;
                end
                if (m_tdata[79:48] !== want.delay)
                begin
                    $error("wait_delay expected %0d actual %0d", want.delay, m_tdata[79:48]);
                    errors++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last_record expected %0d actual %0d", want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // receiver hold-off: counted in its own process so the sender keeps going
    task automatic hold_receiver(int n);
        hold_sink = 1;
        repeat (n) @(posedge clk);
        hold_sink = 0;
    endtask

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC)
        begin
            $display("deadline_fifo_job_dispatcher_tb failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- main sequence
    initial
    begin
        errors = 0; cycles = 0; sent = 0; now_t = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
        cfg_we = 1'b0; cfg_wdata = '0;
        lim_reg = LIMIT_RESET;
        clear_sched();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // random phases across limit settings, each ending with an end marker
        for (int ph = 0; ph < 6; ph++)
        begin
            write_limit(ph == 0 ? 3'd0 : ph == 1 ? 3'd7 : 3'($urandom_range(0, 7)));
            now_t = $urandom_range(0, 1000);
            if (ph == 2)
                fork
                    hold_receiver(400);
                join_none
            if (ph == 5) idle_ok = 0;
            for (int k = 0; k < 45; k++)
            begin
                if (k == 20 && ph == 3) write_limit(3'd1);  // lowered with jobs waiting
                send_job(rand_job($urandom_range(0, 9) == 0));
            end
            send_job(mk(FUNC_END, 16'($urandom), $urandom, $urandom, $urandom));
        end

        wait_drained();
        if (errors == 0)
            $display("deadline_fifo_job_dispatcher_tb passed");
        else
            $display("deadline_fifo_job_dispatcher_tb failed");
        $finish;
    end

endmodule
